/* hdl/ctafc_pkg.sv */
// Package for the crystal-tune AFC loop: register indexes, field widths,
// configuration and result structs shared by the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ctafc_pkg;

	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 11;
	localparam int unsigned FifoW     = 11;
	localparam int unsigned CountW    = 4;
	localparam int unsigned InDataW   = 48;
	localparam int unsigned OutDataW  = 16;

	// Event count value that requests a forced phase unlock.
	localparam logic [CountW-1:0] UnlockMark = 4'd10;

	typedef enum logic [CfgIdxW-1:0] {
		REG_JUMP_LIMIT      = 3'd0,
		REG_COARSE_LIMIT    = 3'd1,
		REG_FIFO_FULL_LEVEL = 3'd2,
		REG_FIFO_HIGH_LEVEL = 3'd3,
		REG_FIFO_LOW_LEVEL  = 3'd4,
		REG_FINE_PERIOD     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]        jump_limit;
		logic [7:0]        coarse_limit;
		logic [FifoW-1:0]  fifo_full_level;
		logic [FifoW-1:0]  fifo_high_level;
		logic [FifoW-1:0]  fifo_low_level;
		logic [CountW-1:0] fine_period;
	} cfg_t;

	typedef struct packed {
		logic        irq_seen;
		logic [31:0] status_word;
		logic [7:0]  tune_in;
	} event_t;

	typedef struct packed {
		logic [7:0] tune_out;
		logic       write_tune;
		logic       force_unlock;
	} result_t;

	typedef struct packed {
		logic signed [7:0] last_offset;
		logic [CountW-1:0] event_count;
	} loop_state_t;

endpackage

/* hdl/ctafc_calc.sv */
// Combinational datapath of the crystal-tune AFC loop: decodes one event,
// computes the new tune byte and the next loop state. Uses ctafc_pkg.
`timescale 1ns / 1ps

module ctafc_calc (
	input  ctafc_pkg::cfg_t        cfg,
	input  ctafc_pkg::event_t      evt,
	input  ctafc_pkg::loop_state_t state_cur,
	output ctafc_pkg::loop_state_t state_nxt,
	output ctafc_pkg::result_t     result
);
	import ctafc_pkg::*;

	logic signed [15:0] raw_ext;
	logic signed [15:0] raw_bias;
	logic signed [7:0]  offset;
	logic signed [8:0]  diff;
	logic [8:0]         diff_abs;
	logic               suppress;
	logic signed [7:0]  eff;
	logic [8:0]         eff_abs;
	logic signed [9:0]  eff3;
	logic signed [9:0]  coarse_corr;
	logic signed [9:0]  corr;
	logic signed [9:0]  cap;
	logic [6:0]         cap_clamped;
	logic [FifoW-1:0]   fifo;
	logic [CountW-1:0]  cnt_mid;
	logic               unlock;

	always_comb begin
		// Offset in ppm: signed 15-bit raw value divided by 128 toward zero.
		raw_ext  = {evt.status_word[14], evt.status_word[14:0]};
		raw_bias = raw_ext + (evt.status_word[14] ? 16'sd127 : 16'sd0);
		offset   = raw_bias[14:7];
		fifo     = evt.status_word[29:19];

		diff     = {offset[7], offset} - {state_cur.last_offset[7], state_cur.last_offset};
		diff_abs = diff[8] ? 9'(-diff) : 9'(diff);
		suppress = diff_abs >= {1'b0, cfg.jump_limit};
		eff      = suppress ? 8'sd0 : offset;
		eff_abs  = eff[7] ? 9'(-{eff[7], eff}) : {1'b0, eff};

		// Coarse step is offset * 3 / 2, truncated toward zero.
		eff3        = {{2{eff[7]}}, eff} + {eff[7], eff, 1'b0};
		coarse_corr = (eff3 + (eff3[9] ? 10'sd1 : 10'sd0)) >>> 1;

		if (eff_abs >= {1'b0, cfg.coarse_limit}) begin
			corr    = coarse_corr;
			cnt_mid = UnlockMark;
		end else if (fifo >= cfg.fifo_full_level) begin
			corr    = 10'sd0;
			cnt_mid = UnlockMark;
		end else if (state_cur.event_count == cfg.fine_period) begin
			if (fifo > cfg.fifo_high_level) begin
				corr = 10'sd1;
			end else if (fifo < cfg.fifo_low_level && (eff[7] || eff == 8'sd0)) begin
				corr = -10'sd1;
			end else begin
				corr = 10'sd0;
			end
			cnt_mid = CountW'(1);
		end else begin
			corr    = 10'sd0;
			cnt_mid = state_cur.event_count + CountW'(1);
		end

		cap = $signed({3'b000, evt.tune_in[6:0]}) - corr;
		if (cap[9]) begin
			cap_clamped = 7'd0;
		end else if (cap > 10'sd127) begin
			cap_clamped = 7'd127;
		end else begin
			cap_clamped = cap[6:0];
		end

		unlock = (cnt_mid == UnlockMark);

		if (evt.irq_seen) begin
			state_nxt.last_offset = offset;
			state_nxt.event_count = unlock ? CountW'(1) : cnt_mid;
			result.tune_out       = {evt.tune_in[7], cap_clamped};
			result.write_tune     = 1'b1;
			result.force_unlock   = unlock;
		end else begin
			// No interrupt: only the event counter is rearmed.
			state_nxt.last_offset = state_cur.last_offset;
			state_nxt.event_count = CountW'(1);
			result.tune_out       = evt.tune_in;
			result.write_tune     = 1'b0;
			result.force_unlock   = 1'b0;
		end
	end

endmodule

/* hdl/crystal_tune_afc_loop.sv */
// Top level of the crystal-tune automatic frequency control loop.
// Depends on ctafc_pkg and ctafc_calc.
`timescale 1ns / 1ps

// Usage:
// One tracking event enters per transaction on the s_ channel. Each event
// yields exactly one result transaction on the m_ channel, carrying the new
// tune byte, a write-back flag and a forced phase unlock request.
// Events go into an input register; the decode, jump filter, correction and
// clamp are computed combinationally from that register and the loop state
// and land in the result register. An accepted event passes through the
// input register and then the result register before its result
// transaction can complete. One event is taken in every cycle while results
// are drained. The loop state (last offset, event counter) is updated when an
// event moves from the input register to the result register, so the next
// event sees it at once.
// When the receiver holds m_tready low, the result register keeps its value,
// the input register fills, and then s_tready drops until space frees up.
// The configuration channel is always ready and writes one register per
// transaction; indexes above five are ignored. It is meant to be used only
// while no event is in flight. Reset clears both registers' valid flags, the
// loop state and restores the register defaults.

module crystal_tune_afc_loop (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, from bit 0: irq_seen[0], status_word[32:1], tune_in[40:33], zero[47:41]
	input  logic [ctafc_pkg::InDataW-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata, from bit 0: tune_out[7:0], write_tune[8], force_unlock[9], zero[15:10]
	output logic [ctafc_pkg::OutDataW-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ctafc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [ctafc_pkg::CfgDataW-1:0]      cfg_data
);
	import ctafc_pkg::*;

	cfg_t        cfg_q;
	event_t      evt_s1;
	logic        valid_s1;
	result_t     res_s2;
	logic        valid_s2;
	loop_state_t state_q;
	loop_state_t state_nxt;
	result_t     res_nxt;
	logic        advance;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Register file: values wider than a register are cut to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_limit      <= 8'd2;
			cfg_q.coarse_limit    <= 8'd8;
			cfg_q.fifo_full_level <= FifoW'(28);
			cfg_q.fifo_high_level <= FifoW'(20);
			cfg_q.fifo_low_level  <= FifoW'(12);
			cfg_q.fine_period     <= CountW'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_JUMP_LIMIT:      cfg_q.jump_limit      <= cfg_data[7:0];
				REG_COARSE_LIMIT:    cfg_q.coarse_limit    <= cfg_data[7:0];
				REG_FIFO_FULL_LEVEL: cfg_q.fifo_full_level <= cfg_data[FifoW-1:0];
				REG_FIFO_HIGH_LEVEL: cfg_q.fifo_high_level <= cfg_data[FifoW-1:0];
				REG_FIFO_LOW_LEVEL:  cfg_q.fifo_low_level  <= cfg_data[FifoW-1:0];
				REG_FINE_PERIOD:     cfg_q.fine_period     <= cfg_data[CountW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			evt_s1.irq_seen    <= s_tdata[0];
			evt_s1.status_word <= s_tdata[32:1];
			evt_s1.tune_in     <= s_tdata[40:33];
		end
	end

	ctafc_calc u_calc (
		.cfg       (cfg_q),
		.evt       (evt_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (res_nxt)
	);

	// Loop state follows each event as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_offset <= 8'sd0;
			state_q.event_count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b000000, res_s2.force_unlock, res_s2.write_tune, res_s2.tune_out};

endmodule

/* hdl/ctafc_chk.sv */
// Port-level checker for the crystal-tune AFC loop, bound to the top level.
// Depends on ctafc_pkg for the data widths.
`timescale 1ns / 1ps

module ctafc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ctafc_pkg::OutDataW-1:0] m_tdata
);
	import ctafc_pkg::*;

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An unlock request only comes with a tune write.
	a_unlock_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8])
		else $error("unlock request without tune write");

	// Padding bits of the result stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:10] == 6'b000000)
		else $error("result padding not zero");

	// An accepted event reaches the output when the receiver does not stall it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted event did not produce a result");

endmodule

bind crystal_tune_afc_loop ctafc_chk u_ctafc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
